>>> hdl/rdte_pkg.sv
// Shared types and constants of the relocation delta table encoder.
`default_nettype none

package rdte_pkg;

  // Default widths of image offsets and of the skip-byte run counter
  localparam int OFFSET_BITS_DEF = 32;
  localparam int RUN_BITS_DEF    = 25;

  // Fixed field widths of the result request
  localparam int BYTE_W = 8;
  localparam int REP_W  = 25;
  localparam int SIZE_W = 32;

  // Most results that one input request can cause
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  // Encoding constants
  localparam logic [8:0]        STEP_GAP     = 9'd254;
  localparam logic [7:0]        TAG_MASK     = 8'd7;
  localparam logic [7:0]        LONG_TAG     = 8'd5;
  localparam logic [SIZE_W-1:0] OFFSET_BYTES = 32'd4;

  // Kind of input request
  typedef enum logic {
    ACT_WORD = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  // One result request
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [REP_W-1:0]  repeat_res;
    logic              last;
    logic [SIZE_W-1:0] table_size;
  } res_t;

  // Results of one input request, in output order, with their count
  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    res_t [MAX_RES-1:0]        res;
  } batch_t;

endpackage

`default_nettype wire

>>> hdl/rdte_encode.sv
// Encoder state and the single-pass result computation for one request.
`default_nettype none

module rdte_encode #(
  parameter int OFFSET_BITS = rdte_pkg::OFFSET_BITS_DEF,
  parameter int RUN_BITS    = rdte_pkg::RUN_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire rdte_pkg::action_t action,
  input  wire logic [7:0]       tag_byte,
  output rdte_pkg::batch_t      batch
);

  localparam logic [RUN_BITS-1:0] RUN_MAX = {RUN_BITS{1'b1}};

  logic [OFFSET_BITS-1:0]      pos_r, pos_nxt;
  logic                        nrel_r, nrel_nxt;
  logic                        skip_r, skip_nxt;
  logic [RUN_BITS-1:0]         pend_r, pend_nxt;
  logic [7:0]                  gap_r, gap_nxt;
  logic [rdte_pkg::SIZE_W-1:0] bw_r, bw_nxt;

  logic [8:0]                  gap_sum;
  logic                        gap_wrap;
  logic [7:0]                  gap_adv;
  logic [RUN_BITS-1:0]         pend_adv;
  logic [OFFSET_BITS-1:0]      pos_inc;
  logic [31:0]                 pos32;
  logic [rdte_pkg::SIZE_W-1:0] term;

  // Gap bookkeeping for a word that is not a relocation
  assign gap_sum  = {1'b0, gap_r} + 9'd2;
  assign gap_wrap = gap_sum > rdte_pkg::STEP_GAP;
  assign gap_adv  = gap_wrap ? 8'(gap_sum - rdte_pkg::STEP_GAP) : gap_sum[7:0];
  assign pend_adv = (gap_wrap && (pend_r != RUN_MAX)) ? pend_r + 1'b1 : pend_r;
  assign pos_inc  = pos_r + OFFSET_BITS'(2);
  assign pos32    = 32'(pos_r);
  assign term     = nrel_r ? rdte_pkg::OFFSET_BYTES : 32'd1;

  always_comb begin
    pos_nxt  = pos_r;
    nrel_nxt = nrel_r;
    skip_nxt = skip_r;
    pend_nxt = pend_r;
    gap_nxt  = gap_r;
    bw_nxt   = bw_r;
    batch    = '0;
    if (go) begin
      if (action == rdte_pkg::ACT_END) begin
        batch.cnt                  = rdte_pkg::CNT_W'(1);
        batch.res[0].out_byte      = 8'd0;
        batch.res[0].repeat_res    = rdte_pkg::REP_W'(term);
        batch.res[0].last          = 1'b1;
        batch.res[0].table_size    = bw_r + term;
        pos_nxt  = '0;
        nrel_nxt = 1'b1;
        skip_nxt = 1'b0;
        pend_nxt = '0;
        gap_nxt  = '0;
        bw_nxt   = '0;
      end else if (skip_r || ((tag_byte & rdte_pkg::TAG_MASK) != rdte_pkg::LONG_TAG)) begin
        // plain word or second half of a long relocation: advance only
        skip_nxt = 1'b0;
        pos_nxt  = pos_inc;
        gap_nxt  = gap_adv;
        pend_nxt = pend_adv;
      end else begin
        if (nrel_r) begin
          batch.cnt               = rdte_pkg::CNT_W'(4);
          batch.res[0].out_byte   = pos32[31:24];
          batch.res[1].out_byte   = pos32[23:16];
          batch.res[2].out_byte   = pos32[15:8];
          batch.res[3].out_byte   = pos32[7:0];
          batch.res[0].repeat_res = rdte_pkg::REP_W'(1);
          batch.res[1].repeat_res = rdte_pkg::REP_W'(1);
          batch.res[2].repeat_res = rdte_pkg::REP_W'(1);
          batch.res[3].repeat_res = rdte_pkg::REP_W'(1);
          bw_nxt   = bw_r + rdte_pkg::OFFSET_BYTES;
          nrel_nxt = 1'b0;
        end else if (pend_r != '0) begin
          batch.cnt               = rdte_pkg::CNT_W'(2);
          batch.res[0].out_byte   = 8'd1;
          batch.res[0].repeat_res = rdte_pkg::REP_W'(pend_r);
          batch.res[1].out_byte   = gap_r;
          batch.res[1].repeat_res = rdte_pkg::REP_W'(1);
          bw_nxt = bw_r + 32'(pend_r) + 32'd1;
        end else begin
          batch.cnt               = rdte_pkg::CNT_W'(1);
          batch.res[0].out_byte   = gap_r;
          batch.res[0].repeat_res = rdte_pkg::REP_W'(1);
          bw_nxt = bw_r + 32'd1;
        end
        pend_nxt = '0;
        gap_nxt  = 8'd2;
        skip_nxt = 1'b1;
        pos_nxt  = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      nrel_r <= 1'b1;
      skip_r <= 1'b0;
      pend_r <= '0;
      gap_r  <= '0;
      bw_r   <= '0;
    end else begin
      pos_r  <= pos_nxt;
      nrel_r <= nrel_nxt;
      skip_r <= skip_nxt;
      pend_r <= pend_nxt;
      gap_r  <= gap_nxt;
      bw_r   <= bw_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rdte_resq.sv
// Result register bank: holds the results of one request and drains them in order.
`default_nettype none

module rdte_resq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rdte_pkg::batch_t batch,
  input  wire logic             pop,
  output logic                  room,
  output logic                  res_vld,
  output rdte_pkg::res_t        res
);

  rdte_pkg::res_t                 ent_r [rdte_pkg::MAX_RES];
  logic [rdte_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [rdte_pkg::IDX_W-1:0]     head_r, head_nxt;
  logic                           pop_ok;

  assign res_vld = cnt_r != '0;
  assign res     = ent_r[head_r];
  // a result leaves only when one is actually offered
  assign pop_ok  = pop && res_vld;
  // free for a new batch once the last held result leaves
  assign room    = (cnt_r == '0) || ((cnt_r == rdte_pkg::CNT_W'(1)) && pop);

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    if (load) begin
      cnt_nxt  = batch.cnt;
      head_nxt = '0;
    end else if (pop_ok) begin
      cnt_nxt  = cnt_r - 1'b1;
      head_nxt = head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < rdte_pkg::MAX_RES; i++) begin
        ent_r[i] <= batch.res[i];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= rdte_pkg::CNT_W'(rdte_pkg::MAX_RES))
    else $error("result count above capacity");

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> room)
    else $error("batch loaded over undelivered results");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && res_vld && !load) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("drain did not lower the result count");

endmodule

`default_nettype wire

>>> hdl/relocation_delta_table_encoder_core.sv
// Top level of the relocation delta table encoder: input register, encoder, result bank.
//
// Usage:
//   Input stream (in_*): one request per 2-byte relocation word of the image, or an
//   end request (in_tuser = 1) that closes the image. in_tdata carries the word's tag
//   byte; a tag whose low three bits equal 5 marks a long relocation, and the word
//   after it is taken without inspection.
//   Result stream (out_*): table bytes with a repeat count; out_tlast marks the
//   terminator, which also carries the total table size in bytes.
//   Flow: a request is registered on acceptance and its batch is loaded into the
//   result bank once the bank has room; the first result is then offered on out_*.
//   Throughput: one request per cycle while it causes at most one result and the
//   receiver does not stall; a request causing k results holds the bank until all k
//   have left (k is 4 for the first relocation of an image, 1 or 2 for later ones).
//   The result bank drain sets it.
//   Reset (rst_n low, synchronous) empties both stages and starts a fresh image.
//   When the receiver stalls, held results wait and the input register fills, after
//   which in_tready drops; no request is lost.
`default_nettype none

module relocation_delta_table_encoder_core #(
  parameter int OFFSET_BITS = rdte_pkg::OFFSET_BITS_DEF,
  parameter int RUN_BITS    = rdte_pkg::RUN_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] tag_byte
  input  wire logic        in_tuser,   // [0] action (1 = end of image)
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [7:0] out_byte, [32:8] repeat_res,
                                       // [64:33] table_size, [71:65] zero
  output logic             out_tlast   // terminator of the image
);

  logic                 in_vld_r;
  rdte_pkg::action_t    act_r;
  logic [7:0]           tag_r;
  logic                 take;
  logic                 room;
  logic                 res_vld;
  rdte_pkg::res_t       res;
  rdte_pkg::batch_t     batch;

  // hand the registered request to the encoder when the result bank can take its batch
  assign take      = in_vld_r && room;
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // payload: hold while the request waits
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      act_r <= rdte_pkg::action_t'(in_tuser);
      tag_r <= in_tdata;
    end
  end

  rdte_encode #(
    .OFFSET_BITS (OFFSET_BITS),
    .RUN_BITS    (RUN_BITS)
  ) u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (take),
    .action   (act_r),
    .tag_byte (tag_r),
    .batch    (batch)
  );

  rdte_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (take),
    .batch   (batch),
    .pop     (out_tready),
    .room    (room),
    .res_vld (res_vld),
    .res     (res)
  );

  assign out_tvalid = res_vld;
  assign out_tlast  = res.last;
  assign out_tdata  = {7'd0, res.table_size, res.repeat_res, res.out_byte};

endmodule

`default_nettype wire

>>> tb/tb_relocation_delta_table_encoder_core.sv
// Self-checking testbench of the relocation delta table encoder core.
`timescale 1ns / 1ps

module tb_relocation_delta_table_encoder_core;

  localparam logic [rdte_pkg::REP_W-1:0] ONES_RUN_MAX = '1;

  // Scoreboard: tracks the table state of the current image and holds the
  // results still owed by the block, oldest first.
  class reloc_table_scoreboard;
    logic [31:0]                 position;
    bit                          no_reloc_yet;
    bit                          skip_next;
    logic [rdte_pkg::REP_W-1:0]  ones_run;
    logic [7:0]                  gap_rem;
    logic [rdte_pkg::SIZE_W-1:0] bytes_written;
    rdte_pkg::res_t              owed_q[$];
    int                          errors;

    function new();
      errors = 0;
      clear_image();
    endfunction

    function void clear_image();
      position      = '0;
      no_reloc_yet  = 1'b1;
      skip_next     = 1'b0;
      ones_run      = '0;
      gap_rem       = '0;
      bytes_written = '0;
    endfunction

    function void owe(logic [7:0] b, logic [rdte_pkg::REP_W-1:0] rep, logic lst,
                      logic [rdte_pkg::SIZE_W-1:0] size);
      rdte_pkg::res_t r;
      r.out_byte   = b;
      r.repeat_res = rep;
      r.last       = lst;
      r.table_size = size;
      owed_q.push_back(r);
    endfunction

    // Advance one plain word: fold every full 254-byte step into the run.
    function void pass_word();
      logic [8:0] g;
      position = position + 32'd2;
      g = {1'b0, gap_rem} + 9'd2;
      if (g > rdte_pkg::STEP_GAP) begin
        g = g - rdte_pkg::STEP_GAP;
        if (ones_run != ONES_RUN_MAX) ones_run = ones_run + 1'b1;
      end
      gap_rem = g[7:0];
    endfunction

    function void note_request(rdte_pkg::action_t act, logic [7:0] tag);
      logic [rdte_pkg::SIZE_W-1:0] term;
      if (act == rdte_pkg::ACT_END) begin
        term = no_reloc_yet ? rdte_pkg::OFFSET_BYTES : 32'd1;
        owe(8'd0, term[rdte_pkg::REP_W-1:0], 1'b1, bytes_written + term);
        clear_image();
        return;
      end
      if (skip_next) begin
        skip_next = 1'b0;
        pass_word();
        return;
      end
      if ((tag & rdte_pkg::TAG_MASK) != rdte_pkg::LONG_TAG) begin
        pass_word();
        return;
      end
      if (no_reloc_yet) begin
        owe(position[31:24], rdte_pkg::REP_W'(1), 1'b0, '0);
        owe(position[23:16], rdte_pkg::REP_W'(1), 1'b0, '0);
        owe(position[15:8],  rdte_pkg::REP_W'(1), 1'b0, '0);
        owe(position[7:0],   rdte_pkg::REP_W'(1), 1'b0, '0);
        bytes_written = bytes_written + rdte_pkg::OFFSET_BYTES;
        no_reloc_yet  = 1'b0;
      end else begin
        if (ones_run != '0) begin
          owe(8'd1, ones_run, 1'b0, '0);
          bytes_written = bytes_written + rdte_pkg::SIZE_W'(ones_run);
        end
        owe(gap_rem, rdte_pkg::REP_W'(1), 1'b0, '0);
        bytes_written = bytes_written + 32'd1;
      end
      ones_run  = '0;
      skip_next = 1'b1;
      position  = position + 32'd2;
      gap_rem   = 8'd2;
    endfunction

    function void check_result(rdte_pkg::res_t got);
      rdte_pkg::res_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: byte %0d repeat %0d", got.out_byte,
               got.repeat_res);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte expected %0d actual %0d", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.repeat_res !== want.repeat_res) begin
        $error("repeat_res expected %0d actual %0d", want.repeat_res, got.repeat_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
      if (got.table_size !== want.table_size) begin
        $error("table_size expected %0d actual %0d", want.table_size, got.table_size);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;   // [7:0] tag_byte
  logic        in_tuser   = 1'b0;   // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;           // [7:0] out_byte, [32:8] repeat_res,
                                    // [64:33] table_size, [71:65] zero
  logic        out_tlast;

  reloc_table_scoreboard sb;
  int send_idle_pct = 0;  // chance per cycle that the sender holds off
  int recv_stall_pct = 0; // chance per cycle that the receiver stalls
  int items_sent = 0;

  relocation_delta_table_encoder_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Receiver: check every accepted result, then pick next cycle's ready.
  // Values read here are the ones from before the edge.
  always @(posedge clk) begin
    rdte_pkg::res_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.out_byte   = out_tdata[7:0];
        got.repeat_res = out_tdata[32:8];
        got.table_size = out_tdata[64:33];
        got.last       = out_tlast;
        sb.check_result(got);
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request, with a random lead-in gap, and hold it until taken.
  // Valid is only lowered when a gap starts, so back-to-back requests keep
  // it high without a second assignment in the same step.
  task automatic send_request(rdte_pkg::action_t act, logic [7:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tag;
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, tag);
    items_sent++;
  endtask

  task automatic send_word(logic [7:0] tag);
    send_request(rdte_pkg::ACT_WORD, tag);
  endtask

  task automatic send_end();
    send_request(rdte_pkg::ACT_END, 8'($urandom_range(255)));
  endtask

  // Hold off the sender until every owed result is back, then let the
  // pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Plain word: random tag that never marks a long relocation, with a little
  // noise of fully random tags.
  task automatic send_plain();
    logic [7:0] tag;
    tag = 8'($urandom_range(255));
    if ($urandom_range(99) >= 8 && (tag & rdte_pkg::TAG_MASK) == rdte_pkg::LONG_TAG)
      tag ^= 8'h01;
    send_word(tag);
  endtask

  task automatic send_long();
    logic [7:0] tag;
    tag = {5'($urandom_range(31)), 3'b000} | rdte_pkg::LONG_TAG;
    send_word(tag);
  endtask

  // One image: a few relocations separated by mostly short gaps, sometimes
  // gaps around the 254-byte step so the 1-byte runs show up.
  task automatic send_image();
    int relocs;
    int gap;
    int pick;
    relocs = $urandom_range(5);
    for (int r = 0; r < relocs; r++) begin
      pick = $urandom_range(99);
      if (pick < 85) gap = $urandom_range(8);
      else gap = $urandom_range(122, 132);
      repeat (gap) send_plain();
      send_long();
      // skipped second half: any tag, long relocation marks included
      if ($urandom_range(99) < 90) send_word(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 30) repeat ($urandom_range(4)) send_plain();
    send_end();
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty image, first relocation, skipped long tag, tags with
    // several other values of the marker bits, end while a skip is pending.
    send_end();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(8'h05);
    send_word(8'h05);
    send_word(8'h0D);
    send_word(8'hF8);
    send_word(8'hFD);
    send_word(8'h00);
    send_word(8'h05);
    send_end();
    send_word(8'hFD);  // first relocation at offset zero
    send_word(8'hAA);
    send_end();
    send_end();
    send_word(8'h07);
    send_word(8'h06);
    send_word(8'h04);
    send_word(8'h01);
    send_word(8'hF5);
    send_end();
    drain();

    // Random: four idle settings, draining between them.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      while (items_sent < (phase + 1) * 100) send_image();
      drain();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
